// ===== sv/hid_boot_keyboard_report_differ_assert.svh =====
`ifndef HID_BOOT_KEYBOARD_REPORT_DIFFER_ASSERT_SVH
`define HID_BOOT_KEYBOARD_REPORT_DIFFER_ASSERT_SVH

// check that post holds in the same cycle as pre
`define HBKRD_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hbkrd: same-cycle check failed");

// check that post holds in the cycle after pre
`define HBKRD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hbkrd: next-cycle check failed");

`endif

// ===== sv/hbkrd_pkg.sv =====
`timescale 1ns / 1ps

package hbkrd_pkg;

    localparam int STEP_W    = 3;
    localparam int MOD_STEPS = 8;
    localparam int MAX_SLOTS = 6;

    localparam logic [7:0] CODE_EMPTY    = 8'h00;
    localparam logic [7:0] CODE_ROLLOVER = 8'h01;
    localparam logic [7:0] CODE_MOD_BASE = 8'hE0;
    localparam logic [7:0] CODE_CAPS     = 8'h39;
    localparam logic [7:0] CODE_SCROLL   = 8'h47;
    localparam logic [7:0] CODE_NUM      = 8'h53;

    localparam logic [2:0] LED_NUM    = 3'b001;
    localparam logic [2:0] LED_CAPS   = 3'b010;
    localparam logic [2:0] LED_SCROLL = 3'b100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRESS,
        ST_RELEASE,
        ST_MODS,
        ST_FLUSH
    } seq_state_t;

    typedef struct packed {
        logic       is_release;
        logic [7:0] keycode;
        logic [7:0] mods;
        logic [2:0] led;
        logic       upd;
        logic       last;
    } event_t;

    // modifier bit visited at each step: lctrl, rctrl, lshift, rshift, lalt, ralt, lgui, rgui
    function automatic logic [2:0] mod_order(input logic [STEP_W-1:0] step);
        logic [2:0] b;
        case (step)
            3'd0:    b = 3'd0;
            3'd1:    b = 3'd4;
            3'd2:    b = 3'd1;
            3'd3:    b = 3'd5;
            3'd4:    b = 3'd2;
            3'd5:    b = 3'd6;
            3'd6:    b = 3'd3;
            3'd7:    b = 3'd7;
            default: b = 3'd0;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] lock_mask(input logic [7:0] code);
        logic [2:0] m;
        case (code)
            CODE_CAPS:   m = LED_CAPS;
            CODE_SCROLL: m = LED_SCROLL;
            CODE_NUM:    m = LED_NUM;
            default:     m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/hid_boot_keyboard_report_differ.sv =====
`timescale 1ns / 1ps

// channel  dir  tdata                                          tuser       tlast
// s_*      in   modifier_byte, key_slot_0 .. key_slot_5        -           -
// m_*      out  event_keycode, event_modifiers, led_state,     is_release  last_event
//               led_update
//
// A report is processed as a sequence of steps, run without a break when the output drains freely:
// an accept step, one step per slot in each key pass, eight modifier steps, one flush step.
// Every key-pass step goes through one shared membership compare (a code against the other list).
// A found event waits in a holding register until the next one is found or the flush step,
// so the final one can carry tlast.
// A stalled output holds the sequencer only on steps that find an event and on the flush step.
// Reset clears the key history, modifier history and lock LEDs at once; no clearing pass.

module hid_boot_keyboard_report_differ
    import hbkrd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // modifier_byte, key_slot_0 .. key_slot_5
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // event_keycode, event_modifiers, led_state, led_update
    output logic [0:0]  m_tuser,   // is_release
    output logic        m_tlast
);

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [STEP_W-1:0] LAST_SLOT = STEP_W'(KEY_SLOTS - 1);
    localparam logic [STEP_W-1:0] LAST_MOD  = STEP_W'(MOD_STEPS - 1);

    seq_state_t state_reg, state_next;

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [7:0]        cur_reg [KEY_SLOTS];
    logic [7:0]        cur_next [KEY_SLOTS];
    logic [7:0]        prev_reg [KEY_SLOTS];
    logic [7:0]        prev_next [KEY_SLOTS];
    logic [7:0]        mods_reg, mods_next;
    logic [7:0]        prev_mods_reg, prev_mods_next;
    logic [2:0]        led_reg, led_next;
    logic              pend_valid_reg, pend_valid_next;
    event_t            pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    event_t            out_reg, out_next;

    logic              slot_phase;
    logic [SLOT_W-1:0] idx;
    logic [7:0]        probe;
    logic              hit;
    logic              skip;
    logic [2:0]        mod_b;
    logic              mod_now;
    logic              mod_was;
    logic [2:0]        mask;
    logic              found;
    logic              step_last;
    logic              advance;
    event_t            ev;

    // shared compare unit
    always_comb
    begin
        slot_phase = (state_reg == ST_PRESS) || (state_reg == ST_RELEASE);
        idx        = slot_phase ? cnt_reg[SLOT_W-1:0] : '0;
        probe      = (state_reg == ST_RELEASE) ? prev_reg[idx] : cur_reg[idx];
        hit        = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++)
        begin
            if (((state_reg == ST_RELEASE) ? cur_reg[j] : prev_reg[j]) == probe)
            begin
                hit = 1'b1;
            end
        end
        skip    = (probe == CODE_EMPTY) || (probe == CODE_ROLLOVER);
        mod_b   = mod_order(cnt_reg);
        mod_now = mods_reg[mod_b];
        mod_was = prev_mods_reg[mod_b];
        mask    = lock_mask(probe);
    end

    // event built by the current step
    always_comb
    begin
        ev        = '0;
        ev.mods   = mods_reg;
        ev.led    = led_reg;
        found     = 1'b0;
        step_last = 1'b0;
        case (state_reg)
            ST_PRESS:
            begin
                found      = !skip && !hit;
                step_last  = (cnt_reg == LAST_SLOT);
                ev.keycode = probe;
                ev.led     = led_reg ^ mask;
                ev.upd     = |mask;
            end
            ST_RELEASE:
            begin
                found         = !skip && !hit;
                step_last     = (cnt_reg == LAST_SLOT);
                ev.is_release = 1'b1;
                ev.keycode    = probe;
            end
            ST_MODS:
            begin
                found         = (mod_now != mod_was);
                step_last     = (cnt_reg == LAST_MOD);
                ev.is_release = mod_was;
                ev.keycode    = CODE_MOD_BASE | {5'b0, mod_b};
            end
            default:
            begin
                found     = 1'b0;
                step_last = 1'b0;
            end
        endcase
        if (state_reg == ST_FLUSH)
        begin
            advance = !pend_valid_reg || !out_valid_reg || m_tready;
        end
        else
        begin
            advance = !found || !pend_valid_reg || !out_valid_reg || m_tready;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PRESS;
                end
            end
            ST_PRESS:
            begin
                if (advance && step_last)
                begin
                    state_next = ST_RELEASE;
                end
            end
            ST_RELEASE:
            begin
                if (advance && step_last)
                begin
                    state_next = ST_MODS;
                end
            end
            ST_MODS:
            begin
                if (advance && step_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        mods_next       = mods_reg;
        prev_mods_next  = prev_mods_reg;
        led_next        = led_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        cur_next[i] = s_tdata[8 + 8*i +: 8];
                    end
                    mods_next = s_tdata[7:0];
                    cnt_next  = '0;
                end
            end
            ST_PRESS, ST_RELEASE, ST_MODS:
            begin
                if (advance)
                begin
                    cnt_next = step_last ? '0 : STEP_W'(cnt_reg + 1'b1);
                    if (found)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = ev;
                        pend_valid_next = 1'b1;
                        led_next        = ev.led;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (advance)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_next.last  = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    prev_next       = cur_reg;
                    prev_mods_next  = mods_reg;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            prev_mods_reg  <= '0;
            led_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            prev_mods_reg  <= prev_mods_next;
            led_reg        <= led_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            prev_reg       <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        mods_reg <= mods_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.upd, out_reg.led, out_reg.mods, out_reg.keycode};
    assign m_tuser  = out_reg.is_release;
    assign m_tlast  = out_reg.last;

endmodule

// ===== sv/hbkrd_checker.sv =====
`timescale 1ns / 1ps

`include "hid_boot_keyboard_report_differ_assert.svh"

module hbkrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    `HBKRD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `HBKRD_ASSERT_SAME(a_idle_holds_last, s_tready && m_tvalid, m_tlast)
    `HBKRD_ASSERT_SAME(a_led_on_press, m_tvalid && m_tdata[19], !m_tuser[0])
    `HBKRD_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind hid_boot_keyboard_report_differ hbkrd_checker u_hbkrd_checker (.*);
